// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL. Defining NO_ASSERTIONS turns every use into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/satlru_pkg.sv
package satlru_pkg;

    localparam int ADDR_W        = 48;
    localparam int SETS_W        = 7;
    localparam int WAYS_W        = 4;
    localparam int STAMP_W       = 64;
    localparam int FUNC_W        = 3;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 7;
    localparam int MOD_STEP_BITS = 4;

    localparam logic [FUNC_W-1:0] FUNC_ACCESS  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSTALL = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PROBE   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_INVAL   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DIRTY   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SETS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS = 1'b1;

    localparam logic [SETS_W-1:0] SETS_RESET = 7'd64;
    localparam logic [WAYS_W-1:0] WAYS_RESET = 4'd8;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ADDR_W-1:0] line_addr;
    } req_t;

    typedef struct packed {
        logic              found;
        logic              evict_dirty;
        logic [ADDR_W-1:0] evict_addr;
        logic              duplicate;
    } rsp_t;

    typedef struct packed {
        logic              start;
        logic [SETS_W-1:0] divisor;
    } mod_ctl_t;

    typedef struct packed {
        logic              done;
        logic [SETS_W-1:0] rem;
    } mod_stat_t;

endpackage

// File: hw/rtl/set_assoc_tag_store_lru_unit.sv
// An item passes from the accepting edge through the remainder unit, a scan of the
// ways in use and the update step to the result strobe; an unknown command skips the
// first two. One item at a time: a new item is taken only while busy is low, and busy
// falls again in the strobe cycle; the time is set by the shared remainder unit and the way-serial scan.
// Reset: asynchronous, active low; afterwards every entry of the tag memory is cleared
// (NUM_SETS*NUM_WAYS entries, 512 by default) with busy high. Results cannot be stalled.
`include "assert_macros.svh"
module set_assoc_tag_store_lru_unit #(
    parameter int NUM_SETS  = 64,
    parameter int NUM_WAYS  = 8,
    parameter int ADDR_BITS = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [satlru_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [satlru_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                 start,
    input  satlru_pkg::req_t                     req,
    output logic                                 busy,
    output logic                                 done,
    output satlru_pkg::rsp_t                     rsp
);

    import satlru_pkg::*;

    // The tag is the line address cut to ADDR_BITS bits, at most ADDR_W.
    localparam int TAG_W     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int DEPTH     = NUM_SETS * NUM_WAYS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int ENT_W     = 2 + TAG_W + STAMP_W;
    localparam int DIRTY_BIT = STAMP_W + TAG_W;
    localparam int VALID_BIT = STAMP_W + TAG_W + 1;

    // The sequencer: a clearing pass after reset, then per item the set index is
    // worked out by the remainder unit, the ways of the set are read one per cycle
    // through the shared compare logic, and at most a single write finishes the command.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_UPDATE
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [WAY_W-1:0]    issue_way_reg, issue_way_next;
    logic                issue_done_reg, issue_done_next;
    logic                ev_pend_reg, ev_pend_next;
    logic [WAY_W-1:0]    ev_way_reg, ev_way_next;
    logic                hit_reg, hit_next;
    logic                inv_found_reg, inv_found_next;
    logic [STAMP_W-1:0]  clock_reg, clock_next;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;

    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [WAY_W-1:0]    ways_last_reg, ways_last_next;
    logic [AW-1:0]       base_reg, base_next;
    logic [WAY_W-1:0]    hit_way_reg, hit_way_next;
    logic                hit_dirty_reg, hit_dirty_next;
    logic [STAMP_W-1:0]  hit_stamp_reg, hit_stamp_next;
    logic [WAY_W-1:0]    inv_way_reg, inv_way_next;
    logic [WAY_W-1:0]    best_way_reg, best_way_next;
    logic [STAMP_W-1:0]  best_stamp_reg, best_stamp_next;
    logic                best_dirty_reg, best_dirty_next;
    logic [TAG_W-1:0]    best_tag_reg, best_tag_next;

    logic [SETS_W-1:0]   sets_reg;
    logic [WAYS_W-1:0]   ways_reg;
    logic [SETS_W-1:0]   eff_sets;
    logic [WAY_W-1:0]    eff_ways_last;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENT_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENT_W-1:0]    ram_rdata;

    logic                e_valid;
    logic                e_dirty;
    logic [TAG_W-1:0]    e_tag;
    logic [STAMP_W-1:0]  e_stamp;
    logic [STAMP_W-1:0]  clock_inc;
    logic [WAY_W-1:0]    victim_way;

    mod_ctl_t            mod_ctl;
    mod_stat_t           mod_stat;

    satlru_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    satlru_mod #(
        .DIVIDEND_W (TAG_W)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mod_ctl),
        .dividend (TAG_W'(req.line_addr)),
        .stat     (mod_stat)
    );

    // Registers may be written at any time; out-of-range values are clamped when an item starts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sets_reg <= SETS_RESET;
            ways_reg <= WAYS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_SETS: sets_reg <= cfg_wdata;
                CFG_WAYS: ways_reg <= cfg_wdata[WAYS_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        if (sets_reg == '0)
        begin
            eff_sets = SETS_W'(1);
        end
        else if (32'(sets_reg) > NUM_SETS)
        begin
            eff_sets = SETS_W'(NUM_SETS);
        end
        else
        begin
            eff_sets = sets_reg;
        end

        if (ways_reg == '0)
        begin
            eff_ways_last = '0;
        end
        else if (32'(ways_reg) > NUM_WAYS)
        begin
            eff_ways_last = WAY_W'(NUM_WAYS - 1);
        end
        else
        begin
            eff_ways_last = WAY_W'(ways_reg - 1'b1);
        end
    end

    // Fields of the entry read in the previous cycle.
    assign e_valid   = ram_rdata[VALID_BIT];
    assign e_dirty   = ram_rdata[DIRTY_BIT];
    assign e_tag     = ram_rdata[STAMP_W +: TAG_W];
    assign e_stamp   = ram_rdata[STAMP_W-1:0];
    assign clock_inc = clock_reg + STAMP_W'(1);
    assign ram_raddr = base_reg + AW'(issue_way_reg);

    // An install fills the lowest invalid way, otherwise the oldest stamp.
    assign victim_way = inv_found_reg ? inv_way_reg : best_way_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        issue_way_next  = issue_way_reg;
        issue_done_next = issue_done_reg;
        ev_pend_next    = 1'b0;
        ev_way_next     = ev_way_reg;
        hit_next        = hit_reg;
        inv_found_next  = inv_found_reg;
        clock_next      = clock_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        func_next       = func_reg;
        tag_next        = tag_reg;
        ways_last_next  = ways_last_reg;
        base_next       = base_reg;
        hit_way_next    = hit_way_reg;
        hit_dirty_next  = hit_dirty_reg;
        hit_stamp_next  = hit_stamp_reg;
        inv_way_next    = inv_way_reg;
        best_way_next   = best_way_reg;
        best_stamp_next = best_stamp_reg;
        best_dirty_next = best_dirty_reg;
        best_tag_next   = best_tag_reg;
        mod_ctl         = '0;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    func_next      = req.func;
                    tag_next       = TAG_W'(req.line_addr);
                    ways_last_next = eff_ways_last;
                    if (req.func inside {FUNC_ACCESS, FUNC_INSTALL, FUNC_PROBE,
                                         FUNC_INVAL, FUNC_DIRTY})
                    begin
                        mod_ctl.start   = 1'b1;
                        mod_ctl.divisor = eff_sets;
                        state_next      = S_MOD;
                    end
                    else
                    begin
                        // An unknown command touches nothing and returns all zeros.
                        state_next = S_UPDATE;
                    end
                end
            end

            S_MOD:
            begin
                if (mod_stat.done)
                begin
                    base_next       = AW'(32'(mod_stat.rem) * NUM_WAYS);
                    issue_way_next  = '0;
                    issue_done_next = 1'b0;
                    hit_next        = 1'b0;
                    inv_found_next  = 1'b0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // One read is issued per cycle; its data is compared in the next cycle.
                if (!issue_done_reg)
                begin
                    ev_pend_next = 1'b1;
                    ev_way_next  = issue_way_reg;
                    if (issue_way_reg == ways_last_reg)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        issue_way_next = issue_way_reg + 1'b1;
                    end
                end

                if (ev_pend_reg)
                begin
                    // Where a tag sits in several ways, the lowest one counts.
                    if (e_valid && (e_tag == tag_reg) && !hit_reg)
                    begin
                        hit_next       = 1'b1;
                        hit_way_next   = ev_way_reg;
                        hit_dirty_next = e_dirty;
                        hit_stamp_next = e_stamp;
                    end
                    if (!e_valid && !inv_found_reg)
                    begin
                        inv_found_next = 1'b1;
                        inv_way_next   = ev_way_reg;
                    end
                    // Strictly smaller replaces, so the lowest way wins a tie.
                    if ((ev_way_reg == '0) || (e_stamp < best_stamp_reg))
                    begin
                        best_way_next   = ev_way_reg;
                        best_stamp_next = e_stamp;
                        best_dirty_next = e_dirty;
                        best_tag_next   = e_tag;
                    end
                    if (ev_way_reg == ways_last_reg)
                    begin
                        state_next = S_UPDATE;
                    end
                end
            end

            S_UPDATE:
            begin
                rsp_next   = '0;
                done_next  = 1'b1;
                state_next = S_IDLE;
                case (func_reg)
                    FUNC_ACCESS:
                    begin
                        clock_next     = clock_inc;
                        rsp_next.found = hit_reg;
                        ram_we         = hit_reg;
                        ram_waddr      = base_reg + AW'(hit_way_reg);
                        ram_wdata      = {1'b1, hit_dirty_reg, tag_reg, clock_inc};
                    end
                    FUNC_INSTALL:
                    begin
                        if (hit_reg)
                        begin
                            rsp_next.duplicate = 1'b1;
                        end
                        else
                        begin
                            // The install stamp is the current clock, which stays put.
                            ram_we    = 1'b1;
                            ram_waddr = base_reg + AW'(victim_way);
                            ram_wdata = {1'b1, 1'b0, tag_reg, clock_reg};
                            if (!inv_found_reg && best_dirty_reg)
                            begin
                                rsp_next.evict_dirty = 1'b1;
                                rsp_next.evict_addr  = ADDR_W'(best_tag_reg);
                            end
                        end
                    end
                    FUNC_PROBE:
                    begin
                        rsp_next.found = hit_reg;
                    end
                    FUNC_INVAL:
                    begin
                        rsp_next.found = hit_reg;
                        ram_we         = hit_reg;
                        ram_waddr      = base_reg + AW'(hit_way_reg);
                        ram_wdata      = {1'b0, hit_dirty_reg, tag_reg, hit_stamp_reg};
                    end
                    FUNC_DIRTY:
                    begin
                        rsp_next.found = hit_reg;
                        ram_we         = hit_reg;
                        ram_waddr      = base_reg + AW'(hit_way_reg);
                        ram_wdata      = {1'b1, 1'b1, tag_reg, hit_stamp_reg};
                    end
                    default: ;
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            issue_way_reg  <= '0;
            issue_done_reg <= 1'b0;
            ev_pend_reg    <= 1'b0;
            ev_way_reg     <= '0;
            hit_reg        <= 1'b0;
            inv_found_reg  <= 1'b0;
            clock_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            issue_way_reg  <= issue_way_next;
            issue_done_reg <= issue_done_next;
            ev_pend_reg    <= ev_pend_next;
            ev_way_reg     <= ev_way_next;
            hit_reg        <= hit_next;
            inv_found_reg  <= inv_found_next;
            clock_reg      <= clock_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg        <= rsp_next;
        func_reg       <= func_next;
        tag_reg        <= tag_next;
        ways_last_reg  <= ways_last_next;
        base_reg       <= base_next;
        hit_way_reg    <= hit_way_next;
        hit_dirty_reg  <= hit_dirty_next;
        hit_stamp_reg  <= hit_stamp_next;
        inv_way_reg    <= inv_way_next;
        best_way_reg   <= best_way_next;
        best_stamp_reg <= best_stamp_next;
        best_dirty_reg <= best_dirty_next;
        best_tag_reg   <= best_tag_next;
    end

    // The block is free only when idle, so the strobe cycle itself can take the next item.
    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `ASSERT_NXT(a_done_pulse, done, !done)
    `ASSERT_IMP(a_done_idle, done, !busy)
    `ASSERT_IMP(a_dup_alone, done && rsp.duplicate, !rsp.found && !rsp.evict_dirty)
    `ASSERT_IMP(a_evict_zero, done && !rsp.evict_dirty, rsp.evict_addr == '0)

endmodule

// File: hw/rtl/satlru_ram.sv
module satlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, single read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/satlru_mod.sv
module satlru_mod #(
    parameter int DIVIDEND_W = 48
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  satlru_pkg::mod_ctl_t   ctl,
    input  logic [DIVIDEND_W-1:0]  dividend,
    output satlru_pkg::mod_stat_t  stat
);

    import satlru_pkg::*;

    localparam int STEPS = (DIVIDEND_W + MOD_STEP_BITS - 1) / MOD_STEP_BITS;
    localparam int PAD_W = STEPS * MOD_STEP_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PAD_W-1:0] shift_reg;
    logic [SETS_W-1:0] rem_reg;
    logic [SETS_W-1:0] div_reg;
    logic [SETS_W-1:0] rem_next;

    // Restoring remainder, MOD_STEP_BITS dividend bits per cycle, most significant first.
    always_comb
    begin
        logic [SETS_W:0] r;
        r = {1'b0, rem_reg};
        for (int k = 0; k < MOD_STEP_BITS; k++)
        begin
            r = {r[SETS_W-1:0], shift_reg[PAD_W-1-k]};
            if (r >= {1'b0, div_reg})
            begin
                r = r - {1'b0, div_reg};
            end
        end
        rem_next = r[SETS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(STEPS - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            shift_reg <= PAD_W'(dividend);
            rem_reg   <= '0;
            div_reg   <= ctl.divisor;
        end
        else if (run_reg)
        begin
            shift_reg <= shift_reg << MOD_STEP_BITS;
            rem_reg   <= rem_next;
        end
    end

    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule
